/* rtl/u8u16_pkg.sv */
package u8u16_pkg;

   localparam int unsigned UnitWidth = 16;
   localparam int unsigned CapWidth  = 16;
   localparam int unsigned CpWidth   = 21;

   localparam logic [CapWidth-1:0]  CapacityReset  = 16'd64;
   localparam logic [UnitWidth-1:0] QuestionUnit   = 16'h003F;
   localparam logic [UnitWidth-1:0] TerminatorUnit = 16'h0000;
   localparam logic [UnitWidth-1:0] HighSurrogate  = 16'hD800;
   localparam logic [UnitWidth-1:0] LowSurrogate   = 16'hDC00;
   localparam logic [CpWidth-1:0]   SupplementBase = 21'h010000;

   // Output queue: four entries; a byte is taken only while at least two are free.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [UnitWidth-1:0] code_unit;
      logic                 end_of_string;
   } unit_entry_type;

endpackage

/* rtl/utf8_to_utf16_stream_converter.sv */
// UTF-8 to UTF-16 stream converter. One UTF-8 byte is taken per accepted req word and
// zero, one or two UTF-16 code units leave on the rsp channel; every string closes with
// a zero unit flagged end_of_string, either on NUL or when the buffer size programmed in
// out_capacity would be exceeded, after which bytes are dropped up to the NUL. A byte is
// decoded in the cycle it is accepted and its units are written to a four-entry output
// queue, so the block takes one byte per cycle while req_stall is low. The rsp port
// moves one unit per cycle while rsp_stall is low, so a byte that yields two units (a
// surrogate pair, or '?' before the next unit) needs two rsp transfers; req_stall is
// high while fewer than two queue entries are free. Units reach rsp through the queue.
module utf8_to_utf16_stream_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [u8u16_pkg::UnitWidth-1:0]    rsp_code_unit,
   output logic                               rsp_end_of_string,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [u8u16_pkg::CapWidth-1:0]     csr_out_capacity
);
   import u8u16_pkg::*;

   logic [CapWidth-1:0]  cap_ff;
   logic [1:0]           bp_ff, bp_in;
   logic [CpWidth-1:0]   acc_ff, acc_in;
   logic [UnitWidth-1:0] uw_ff, uw_in;
   logic                 drop_ff, drop_in;

   unit_entry_type       queue_ff [QueueDepth];
   logic [PtrWidth-1:0]  head_ff, tail_ff;
   logic [CntWidth-1:0]  count_ff;

   logic                 req_accept, rsp_accept;
   logic [1:0]           n_units;
   unit_entry_type       e0, e1;

   logic                 start_en;
   logic [UnitWidth-1:0] uw_start;
   logic [CpWidth-1:0]   cp_next;
   logic [CpWidth-1:0]   cp_off;
   logic                 st_emit, st_last;
   logic [UnitWidth-1:0] st_unit;
   logic [CapWidth:0]    cap_need;

   assign csr_ready  = 1'b1;
   assign req_stall  = (count_ff > CntWidth'(QueueDepth - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_code_unit     = queue_ff[head_ff].code_unit;
   assign rsp_end_of_string = queue_ff[head_ff].end_of_string;

   always_comb begin
      bp_in    = bp_ff;
      acc_in   = acc_ff;
      uw_in    = uw_ff;
      drop_in  = drop_ff;
      n_units  = 2'd0;
      e0       = '{code_unit: TerminatorUnit, end_of_string: 1'b0};
      e1       = '{code_unit: TerminatorUnit, end_of_string: 1'b0};
      start_en = 1'b0;
      uw_start = uw_ff;
      cp_next  = {acc_ff[CpWidth-7:0], req_in_byte[5:0]};
      cp_off   = cp_next - SupplementBase;
      st_emit  = 1'b0;
      st_last  = 1'b0;
      st_unit  = TerminatorUnit;
      cap_need = '0;

      if (drop_ff) begin
         if (req_in_byte == 8'h00) begin
            drop_in = 1'b0;
            uw_in   = '0;
            bp_in   = '0;
            acc_in  = '0;
         end
      end else if (bp_ff == 2'd0) begin
         start_en = 1'b1;
      end else if (req_in_byte[7:6] == 2'b10) begin
         bp_in = bp_ff - 2'd1;
         if (bp_ff == 2'd1) begin
            acc_in = '0;
            if (cp_next >= SupplementBase) begin
               n_units = 2'd2;
               e0.code_unit = HighSurrogate | {5'd0, cp_off[20:10]};
               e1.code_unit = LowSurrogate | {6'd0, cp_off[9:0]};
               uw_in = uw_ff + 16'd2;
            end else begin
               n_units = 2'd1;
               e0.code_unit = cp_next[UnitWidth-1:0];
               uw_in = uw_ff + 16'd1;
            end
         end else begin
            acc_in = cp_next;
         end
      end else begin
         // Broken sequence: flag it, then treat this byte as a fresh lead.
         bp_in        = '0;
         acc_in       = '0;
         n_units      = 2'd1;
         e0.code_unit = QuestionUnit;
         uw_start     = uw_ff + 16'd1;
         uw_in        = uw_start;
         start_en     = 1'b1;
      end

      if (start_en) begin
         cap_need = {1'b0, uw_start} + 17'd2;
         priority if (req_in_byte == 8'h00) begin
            st_emit = 1'b1;
            st_last = 1'b1;
            uw_in   = '0;
            bp_in   = '0;
            acc_in  = '0;
         end else if (cap_need >= {1'b0, cap_ff}) begin
            st_emit = 1'b1;
            st_last = 1'b1;
            uw_in   = '0;
            bp_in   = '0;
            acc_in  = '0;
            drop_in = 1'b1;
         end else if (!req_in_byte[7]) begin
            st_emit = 1'b1;
            st_unit = {8'd0, req_in_byte};
            uw_in   = uw_start + 16'd1;
         end else if (req_in_byte[7:5] == 3'b110) begin
            acc_in = {16'd0, req_in_byte[4:0]};
            bp_in  = 2'd1;
         end else if (req_in_byte[7:4] == 4'b1110) begin
            acc_in = {17'd0, req_in_byte[3:0]};
            bp_in  = 2'd2;
         end else if (req_in_byte[7:3] == 5'b11110) begin
            acc_in = {18'd0, req_in_byte[2:0]};
            bp_in  = 2'd3;
         end else begin
            // Stray continuation or invalid lead byte: no sequence is open afterwards.
            bp_in = '0;
         end

         if (st_emit) begin
            if (n_units == 2'd0) begin
               e0 = '{code_unit: st_unit, end_of_string: st_last};
            end else begin
               e1 = '{code_unit: st_unit, end_of_string: st_last};
            end
            n_units = n_units + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CapacityReset;
         bp_ff    <= '0;
         acc_ff   <= '0;
         uw_ff    <= '0;
         drop_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_out_capacity;
         end
         if (req_accept) begin
            bp_ff   <= bp_in;
            acc_ff  <= acc_in;
            uw_ff   <= uw_in;
            drop_ff <= drop_in;
            tail_ff <= tail_ff + PtrWidth'(n_units);
         end
         if (rsp_accept) begin
            head_ff <= head_ff + 1'b1;
         end
         count_ff <= count_ff + (req_accept ? CntWidth'(n_units) : '0)
                     - CntWidth'(rsp_accept);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && n_units != 2'd0) begin
         queue_ff[tail_ff] <= e0;
      end
      if (req_accept && n_units == 2'd2) begin
         queue_ff[tail_ff + 1'b1] <= e1;
      end
   end

endmodule

/* rtl/u8u16_checker.sv */
module u8u16_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [7:0]                      req_in_byte,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [u8u16_pkg::UnitWidth-1:0] rsp_code_unit,
   input logic                            rsp_end_of_string
);
   import u8u16_pkg::*;

   // A held result word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_unit)
         && $stable(rsp_end_of_string))
      else $error("rsp word changed while stalled");

   // A stalled req word stays offered with the same byte.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("req word changed while stalled");

   // The terminator always carries a zero code unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_code_unit == TerminatorUnit)
      else $error("end_of_string on a nonzero unit");

   // Reset empties the output queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   // The input side only backs up when results are waiting.
   assert property (@(posedge clock) req_stall |-> rsp_valid)
      else $error("req_stall with an empty output queue");

endmodule

bind utf8_to_utf16_stream_converter u8u16_checker u_u8u16_checker (.*);
